>>> rtl/neighborhood_3x3_noise_filter_core_macros.svh
// Assertion macros for the 3x3 neighborhood noise filter.
// Used by the top level only; expects clk and rst in scope.
`ifndef NEIGHBORHOOD_3X3_NOISE_FILTER_CORE_MACROS_SVH
`define NEIGHBORHOOD_3X3_NOISE_FILTER_CORE_MACROS_SVH

// Same-cycle implication.
`define NF3_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("nf3 check failed");

// Next-cycle implication.
`define NF3_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("nf3 check failed");

`endif

>>> rtl/nf3_pkg.sv
// Shared types and constants of the 3x3 neighborhood noise filter.
// No dependencies.
`default_nettype none
package nf3_pkg;
  localparam int NWIN        = 9;
  localparam int MEDIAN_RANK = 4;
  localparam int WTW         = 7;
  localparam int SUMW        = 19;
  localparam int TOTW        = 11;
  localparam int SZW         = 13;
  localparam int DIV_STEPS   = 19;
  localparam int RECIP9      = 7282;
  localparam int CFG_IW      = 3;

  localparam logic [1:0] MODE_MEAN   = 2'd0;
  localparam logic [1:0] MODE_MEDIAN = 2'd1;
  localparam logic [1:0] MODE_WEIGHT = 2'd2;

  localparam logic [CFG_IW-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_ROWS    = 3'd1;
  localparam logic [CFG_IW-1:0] REG_COLS    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_WEIGHTS = 3'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_SHIFT, S_ACC, S_DIV, S_FIN, S_OUT
  } nf3_state_t;

  typedef struct packed {
    logic       capture;
    logic       load;
    logic       r_ge1;
    logic       r_ge2;
    logic       c_zero;
    logic       shift;
    logic       acc_en;
    logic [3:0] k;
    logic       bottom;
    logic       div_start;
    logic       div_step;
    logic       finish;
    logic [9:0] row;
    logic [9:0] col;
    logic       last;
    logic       eof;
  } nf3_cmd_t;

  typedef struct packed {
    logic tot_zero;
    logic out_taken;
  } nf3_stat_t;
endpackage
`default_nettype wire

>>> rtl/nf3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module nf3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

>>> rtl/nf3_datapath.sv
// Datapath: line stores, 3x3 window, serial accumulator, median rank test,
// bit-serial divider and output register. Depends on nf3_pkg and nf3_ram.
`default_nettype none
module nf3_datapath
  import nf3_pkg::*;
#(
  parameter int MAX_COLS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire nf3_cmd_t                    cmd,
  input  wire logic [$clog2(MAX_COLS)-1:0] addr,
  input  wire logic [7:0]                  pixel_in,
  input  wire logic [1:0]                  filter_mode,
  input  wire logic [62:0]                 mask_weights,
  output nf3_stat_t                        stat,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [7:0]                       pixel_out,
  output logic [9:0]                       out_row,
  output logic [9:0]                       out_col,
  output logic                             last_in_run,
  output logic                             end_of_frame,
  output logic [7:0]                       frame_min,
  output logic [7:0]                       frame_max,
  output logic                             zero_weight_error
);
  logic [7:0] pix, upper_rd, lower_rd, mid, top;
  logic [7:0] win [3][3];
  logic [7:0] vec [NWIN];
  logic [7:0] vk;
  logic [WTW-1:0] w;
  logic [14:0] prod;
  logic [SUMW-1:0] sum, quo;
  logic [TOTW-1:0] tot, rem;
  logic [TOTW:0] trial;
  logic [7:0] med, res, mean, run_min, run_max, new_min, new_max;
  logic [3:0] lt_cnt, le_cnt;
  logic [24:0] mean_prod;
  logic err;

  nf3_ram #(.WIDTH(8), .DEPTH(MAX_COLS)) u_upper (
    .clk(clk), .we(cmd.load & cmd.r_ge1), .waddr(addr), .wdata(mid),
    .re(cmd.capture), .raddr(addr), .rdata(upper_rd)
  );
  nf3_ram #(.WIDTH(8), .DEPTH(MAX_COLS)) u_lower (
    .clk(clk), .we(cmd.load), .waddr(addr), .wdata(pix),
    .re(cmd.capture), .raddr(addr), .rdata(lower_rd)
  );

  assign mid = cmd.r_ge1 ? lower_rd : 8'd0;
  assign top = cmd.r_ge2 ? upper_rd : mid;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix <= pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int m = 0; m < 3; m++) begin
          win[r][m] <= 8'd0;
        end
      end
    end else if (cmd.load) begin
      for (int r = 0; r < 3; r++) begin
        if (cmd.c_zero) begin
          win[r][0] <= (r == 0) ? top : (r == 1) ? mid : pix;
          win[r][1] <= (r == 0) ? top : (r == 1) ? mid : pix;
        end else begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[r][2] <= (r == 0) ? top : (r == 1) ? mid : pix;
      end
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int m = 0; m < 3; m++) begin
        if (cmd.bottom) begin
          vec[r*3+m] = win[(r == 0) ? 1 : 2][m];
        end else begin
          vec[r*3+m] = win[r][m];
        end
      end
    end
  end

  assign vk = vec[cmd.k];
  assign w  = (filter_mode == MODE_WEIGHT) ? mask_weights[7*cmd.k +: WTW] : WTW'(1);
  assign prod = 15'(w) * 15'(vk);

  always_comb begin
    lt_cnt = 4'd0;
    le_cnt = 4'd0;
    for (int i = 0; i < NWIN; i++) begin
      lt_cnt = lt_cnt + 4'(vec[i] < vk);
      le_cnt = le_cnt + 4'(vec[i] <= vk);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      if (cmd.k == 4'd0) begin
        sum <= SUMW'(prod);
        tot <= TOTW'(w);
      end else begin
        sum <= sum + SUMW'(prod);
        tot <= tot + TOTW'(w);
      end
      if (lt_cnt <= 4'(MEDIAN_RANK) && le_cnt > 4'(MEDIAN_RANK)) begin
        med <= vk;
      end
    end
  end

  assign trial = {rem, quo[SUMW-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      quo <= sum;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, tot}) begin
        rem <= TOTW'(trial - {1'b0, tot});
        quo <= {quo[SUMW-2:0], 1'b1};
      end else begin
        rem <= TOTW'(trial);
        quo <= {quo[SUMW-2:0], 1'b0};
      end
    end
  end

  assign stat.tot_zero  = (tot == '0);
  assign stat.out_taken = out_valid & out_ready;

  assign mean_prod = 25'(sum[11:0]) * 25'(RECIP9);
  assign mean      = mean_prod[23:16];
  assign err       = (filter_mode == MODE_WEIGHT) && (tot == '0);

  always_comb begin
    case (filter_mode)
      MODE_MEDIAN: res = med;
      MODE_WEIGHT: res = err ? 8'd0 : quo[7:0];
      default:     res = mean;
    endcase
  end

  assign new_min = (res < run_min) ? res : run_min;
  assign new_max = (res > run_max) ? res : run_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      run_min   <= 8'hFF;
      run_max   <= 8'h00;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
      run_min   <= cmd.eof ? 8'hFF : new_min;
      run_max   <= cmd.eof ? 8'h00 : new_max;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      pixel_out         <= res;
      out_row           <= cmd.row;
      out_col           <= cmd.col;
      last_in_run       <= cmd.last;
      end_of_frame      <= cmd.eof;
      frame_min         <= cmd.eof ? new_min : 8'd0;
      frame_max         <= cmd.eof ? new_max : 8'd0;
      zero_weight_error <= err;
    end
  end
endmodule
`default_nettype wire

>>> rtl/nf3_ctrl.sv
// Controller: frame position counters and the per-item sequence of
// results, accumulation steps and divider steps. Depends on nf3_pkg.
`default_nettype none
module nf3_ctrl
  import nf3_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  filter_mode,
  input  wire logic [10:0]                 image_rows,
  input  wire logic [10:0]                 image_cols,
  input  wire nf3_stat_t                   stat,
  output nf3_cmd_t                         cmd,
  output logic [$clog2(MAX_COLS)-1:0]      addr
);
  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  nf3_state_t state, state_next;
  logic [RW-1:0] row_cnt, cur_r;
  logic [CW-1:0] col_cnt, cur_c;
  logic eor, lastrow, cur_eor, cur_last;
  logic [SZW-1:0] rows_c, cols_c;
  logic [3:0] slot_en;
  logic [1:0] slot, slot_next, nxt_idx;
  logic nxt_found, shifted, shifted_next;
  logic [3:0] k, k_next;
  logic [4:0] dcnt, dcnt_next;
  logic [3:0] above;
  logic [9:0] r_m1, c_m1;

  always_comb begin
    if (image_rows < 11'd2) rows_c = SZW'(2);
    else if (SZW'(image_rows) > SZW'(MAX_ROWS)) rows_c = SZW'(MAX_ROWS);
    else rows_c = SZW'(image_rows);
    if (image_cols < 11'd2) cols_c = SZW'(2);
    else if (SZW'(image_cols) > SZW'(MAX_COLS)) cols_c = SZW'(MAX_COLS);
    else cols_c = SZW'(image_cols);
  end

  assign eor     = SZW'(col_cnt) >= cols_c - SZW'(1);
  assign lastrow = SZW'(row_cnt) >= rows_c - SZW'(1);

  always_comb begin
    slot_en[0] = (cur_r != '0) && (cur_c != '0);
    slot_en[1] = slot_en[0] && cur_last;
    slot_en[2] = (cur_r != '0) && cur_eor;
    slot_en[3] = slot_en[2] && cur_last;
  end

  always_comb begin
    nxt_found = 1'b0;
    nxt_idx   = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (slot_en[i] && (state == S_LOAD || i > int'(slot))) begin
        nxt_found = 1'b1;
        nxt_idx   = 2'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      above[i] = slot_en[i] && (i > int'(slot));
    end
  end

  assign r_m1 = 10'(cur_r - RW'(1));
  assign c_m1 = 10'(cur_c - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      row_cnt <= '0;
      col_cnt <= '0;
      slot    <= 2'd0;
      shifted <= 1'b0;
      k       <= 4'd0;
      dcnt    <= 5'd0;
    end else begin
      state   <= state_next;
      slot    <= slot_next;
      shifted <= shifted_next;
      k       <= k_next;
      dcnt    <= dcnt_next;
      if (state == S_LOAD) begin
        if (cur_eor) begin
          col_cnt <= '0;
          row_cnt <= cur_last ? '0 : RW'(cur_r + RW'(1));
        end else begin
          col_cnt <= (SZW'(cur_c) == SZW'(MAX_COLS - 1)) ? '0 : CW'(cur_c + CW'(1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur_r    <= row_cnt;
      cur_c    <= col_cnt;
      cur_eor  <= eor;
      cur_last <= lastrow;
    end
  end

  always_comb begin
    state_next   = state;
    slot_next    = slot;
    shifted_next = shifted;
    k_next       = k;
    dcnt_next    = dcnt;
    cmd          = '0;
    cmd.k        = k;
    cmd.bottom   = slot[0];
    cmd.row      = slot[0] ? 10'(cur_r) : r_m1;
    cmd.col      = slot[1] ? 10'(cur_c) : c_m1;
    cmd.last     = (above == 4'd0);
    cmd.eof      = (above == 4'd0) && cur_eor && cur_last;
    in_ready     = 1'b0;
    addr         = cur_c;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        addr     = col_cnt;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.load     = 1'b1;
        cmd.r_ge1    = (cur_r != '0);
        cmd.r_ge2    = (cur_r > RW'(1));
        cmd.c_zero   = (cur_c == '0);
        shifted_next = 1'b0;
        k_next       = 4'd0;
        slot_next    = nxt_idx;
        if (!nxt_found) state_next = S_IDLE;
        else if (nxt_idx[1]) state_next = S_SHIFT;
        else state_next = S_ACC;
      end
      S_SHIFT: begin
        cmd.shift    = 1'b1;
        shifted_next = 1'b1;
        state_next   = S_ACC;
      end
      S_ACC: begin
        cmd.acc_en = 1'b1;
        k_next     = k + 4'd1;
        if (k == 4'(NWIN - 1)) begin
          k_next     = 4'd0;
          dcnt_next  = 5'd0;
          state_next = (filter_mode == MODE_WEIGHT) ? S_DIV : S_FIN;
        end
      end
      S_DIV: begin
        dcnt_next = dcnt + 5'd1;
        if (stat.tot_zero) begin
          state_next = S_FIN;
        end else if (dcnt == 5'd0) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
          if (dcnt == 5'(DIV_STEPS)) state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_taken) begin
          slot_next = nxt_idx;
          if (!nxt_found) state_next = S_IDLE;
          else if (nxt_idx[1] && !shifted) state_next = S_SHIFT;
          else state_next = S_ACC;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/neighborhood_3x3_noise_filter_core.sv
// Top level of the 3x3 neighborhood noise filter: ports, configuration
// registers and checks. Depends on nf3_pkg, nf3_ctrl, nf3_datapath and the macros header.
`default_nettype none
`include "neighborhood_3x3_noise_filter_core_macros.svh"
// Grey pixels enter in raster order and one filtered pixel leaves for each
// position, with edge pixels repeated at the border; filter_mode picks mean,
// median or weighted mask. Each item is captured and then written into the
// line stores and window; each result it causes then passes through the
// nine-step serial accumulator, in weighted mode also through the bit-serial
// divider, and then the output register, where it waits out any output
// stall; the window shifts once before the first row-end result. An item
// causes up to four results, and the next item is taken once the last of
// them has been handed over.
module neighborhood_3x3_noise_filter_core
  import nf3_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,  // pixel_in
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [47:0]            m_axis_tdata,  // pixel_out, out_row, out_col, frame_min, frame_max
  output logic                   m_axis_tlast,
  output logic [1:0]             m_axis_tuser,  // end_of_frame, zero_weight_error
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_IW-1:0] cfg_index,
  input  wire logic [62:0]       cfg_data
);
  logic [1:0]  filter_mode;
  logic [10:0] image_rows, image_cols;
  logic [62:0] mask_weights;
  nf3_cmd_t    cmd;
  nf3_stat_t   stat;
  logic [$clog2(MAX_COLS)-1:0] addr;
  logic [7:0]  pixel_out, frame_min, frame_max;
  logic [9:0]  out_row, out_col;
  logic        end_of_frame, zero_weight_error;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= MODE_MEAN;
      image_rows   <= 11'd1024;
      image_cols   <= 11'd1024;
      mask_weights <= 63'd73187961788711169;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:    filter_mode  <= cfg_data[1:0];
        REG_ROWS:    image_rows   <= cfg_data[10:0];
        REG_COLS:    image_cols   <= cfg_data[10:0];
        REG_WEIGHTS: mask_weights <= cfg_data;
        default: ;
      endcase
    end
  end

  nf3_ctrl #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .filter_mode(filter_mode), .image_rows(image_rows), .image_cols(image_cols),
    .stat(stat), .cmd(cmd), .addr(addr)
  );

  nf3_datapath #(.MAX_COLS(MAX_COLS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .addr(addr), .pixel_in(s_axis_tdata),
    .filter_mode(filter_mode), .mask_weights(mask_weights), .stat(stat),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .pixel_out(pixel_out), .out_row(out_row), .out_col(out_col),
    .last_in_run(m_axis_tlast), .end_of_frame(end_of_frame),
    .frame_min(frame_min), .frame_max(frame_max),
    .zero_weight_error(zero_weight_error)
  );

  assign m_axis_tdata = {4'd0, frame_max, frame_min, out_col, out_row, pixel_out};
  assign m_axis_tuser = {zero_weight_error, end_of_frame};

  `NF3_ASSERT_NOW(a_no_overlap, m_axis_tvalid, !s_axis_tready)
  `NF3_ASSERT_NOW(a_eof_is_last, m_axis_tvalid && end_of_frame, m_axis_tlast)
  `NF3_ASSERT_NOW(a_err_zero, m_axis_tvalid && zero_weight_error, pixel_out == 8'd0)
  `NF3_ASSERT_NEXT(a_accept_loads, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule
`default_nettype wire
